// ----- rtl/owtm_pkg.sv -----
// ----------------------------------------------------------------------------
// owtm_pkg: shared types and constants
// Command codes, configuration indexes and the words passed between the
// configuration file, the sequencer core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package owtm_pkg;

	// tick counter width; register values are taken modulo 2^CntW
	localparam int CntW    = 10;
	localparam int RegW    = 10;
	localparam int CfgIdxW = 3;

	// bus command bytes
	localparam logic [7:0] OW_SKIP_ROM = 8'hcc;
	localparam logic [7:0] OW_CONVERT  = 8'h44;
	localparam logic [7:0] OW_READ_PAD = 8'hbe;

	// reset values of the timing registers
	localparam logic [RegW-1:0] RST_LOW_DEF  = RegW'(480);
	localparam logic [RegW-1:0] PRES_DEF     = RegW'(60);
	localparam logic [RegW-1:0] SLOT_DEF     = RegW'(60);
	localparam logic [RegW-1:0] RD_SMP_DEF   = RegW'(10);
	localparam logic [RegW-1:0] RECOVERY_DEF = RegW'(1);
	localparam logic [RegW-1:0] START_DEF    = RegW'(1);

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_RESET = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_TEMP  = 3'd4
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RST_LOW  = 3'd0,
		REG_PRES     = 3'd1,
		REG_SLOT     = 3'd2,
		REG_RD_SMP   = 3'd3,
		REG_RECOVERY = 3'd4,
		REG_START    = 3'd5
	} reg_idx_t;

	// effective timing values; the ones marked min1 never read as zero
	typedef struct packed {
		logic [CntW-1:0] rst_low;   // min1
		logic [CntW-1:0] pres;
		logic [CntW-1:0] slot;      // min1
		logic [CntW-1:0] rd_smp;
		logic [CntW-1:0] recovery;
		logic [CntW-1:0] start;     // min1
	} timing_t;

	typedef struct packed {
		logic        pull;
		logic        busy;
		logic        done;
		logic        err;
		logic [7:0]  rx;
		logic [15:0] temp;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/owtm_cfg.sv -----
// ----------------------------------------------------------------------------
// owtm_cfg: timing register file
// Six write-only timing registers; presents them trimmed to the counter
// width, with zero lengths forced to one where a slot needs a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module owtm_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [owtm_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [owtm_pkg::RegW-1:0]    cfg_data,
	output owtm_pkg::timing_t                 timing
);
	import owtm_pkg::*;

	logic [RegW-1:0] rst_low_q, pres_q, slot_q, rd_smp_q, recovery_q, start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_low_q  <= RST_LOW_DEF;
			pres_q     <= PRES_DEF;
			slot_q     <= SLOT_DEF;
			rd_smp_q   <= RD_SMP_DEF;
			recovery_q <= RECOVERY_DEF;
			start_q    <= START_DEF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RST_LOW:  rst_low_q  <= cfg_data;
				REG_PRES:     pres_q     <= cfg_data;
				REG_SLOT:     slot_q     <= cfg_data;
				REG_RD_SMP:   rd_smp_q   <= cfg_data;
				REG_RECOVERY: recovery_q <= cfg_data;
				REG_START:    start_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [CntW-1:0] min1(input logic [CntW-1:0] v);
		min1 = (v == '0) ? CntW'(1) : v;
	endfunction

	always_comb begin
		timing.rst_low  = min1(CntW'(rst_low_q));
		timing.pres     = CntW'(pres_q);
		timing.slot     = min1(CntW'(slot_q));
		timing.rd_smp   = CntW'(rd_smp_q);
		timing.recovery = CntW'(recovery_q);
		timing.start    = min1(CntW'(start_q));
	end

endmodule

`default_nettype wire

// ----- rtl/owtm_core.sv -----
// ----------------------------------------------------------------------------
// owtm_core: bus sequencer
// Holds the sequencer state and works out one bus tick per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module owtm_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [2:0]           command,
	input  wire logic [7:0]           tx_byte,
	input  wire logic                 bus_in,
	input  wire owtm_pkg::timing_t    timing,
	output owtm_pkg::result_t         res
);
	import owtm_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
		PH_WR_SLOT, PH_WR_REC, PH_RD_SLOT, PH_POLL
	} phase_t;

	typedef struct packed {
		phase_t          phase;
		logic [CntW-1:0] tick;
		logic [2:0]      bit_idx;
		logic [7:0]      shift;
		logic [3:0]      step;
		logic [15:0]     temp;
		logic            err;
		logic            tmode;   // active command is a temperature read
		logic [7:0]      rx;
	} seq_t;

	seq_t st_q, s;
	logic done, pull, fin, wbd;
	logic [CntW:0] tick_inc, rlen;

	always_comb begin
		s    = st_q;
		done = 1'b0;
		pull = 1'b0;
		fin  = 1'b0;
		wbd  = 1'b0;

		// command start; the start tick is also the first tick of the sequence
		if (s.phase == PH_IDLE && command >= CMD_RESET && command <= CMD_TEMP) begin
			s.err     = 1'b0;
			s.tmode   = (command == CMD_TEMP);
			s.step    = '0;
			s.tick    = '0;
			s.bit_idx = '0;
			s.shift   = '0;
			case (command)
				CMD_WRITE: begin
					s.phase = PH_WR_SLOT;
					s.shift = tx_byte;
				end
				CMD_READ:  s.phase = PH_RD_SLOT;
				CMD_TEMP: begin
					s.phase = PH_RST_LOW;
					s.temp  = '0;
				end
				default:   s.phase = PH_RST_LOW;
			endcase
		end

		tick_inc = (CntW+1)'(s.tick) + (CntW+1)'(1);
		rlen = (timing.slot > timing.rd_smp) ? (CntW+1)'(timing.slot)
		                                     : (CntW+1)'(timing.rd_smp) + (CntW+1)'(1);

		case (s.phase)
			PH_RST_LOW: begin
				pull = 1'b1;
				if (tick_inc >= (CntW+1)'(timing.rst_low)) begin
					s.phase = PH_RST_WAIT;
					s.tick  = '0;
				end else begin
					s.tick = tick_inc[CntW-1:0];
				end
			end
			PH_RST_WAIT: begin
				if (s.tick >= timing.pres) begin
					// presence sample opens the recovery wait on this same tick
					s.err   = bus_in;
					s.phase = PH_RST_REC;
					if (timing.rst_low == CntW'(1)) begin
						fin = 1'b1;
					end else begin
						s.tick = CntW'(1);
					end
				end else begin
					s.tick = tick_inc[CntW-1:0];
				end
			end
			PH_RST_REC: begin
				if (tick_inc >= (CntW+1)'(timing.rst_low)) begin
					fin = 1'b1;
				end else begin
					s.tick = tick_inc[CntW-1:0];
				end
			end
			PH_WR_SLOT: begin
				pull = s.shift[0] ? (s.tick < timing.start) : (s.tick < timing.slot);
				if (tick_inc >= (CntW+1)'(timing.slot)) begin
					if (timing.recovery == '0) begin
						wbd = 1'b1;
					end else begin
						s.phase = PH_WR_REC;
						s.tick  = '0;
					end
				end else begin
					s.tick = tick_inc[CntW-1:0];
				end
			end
			PH_WR_REC: begin
				if (tick_inc >= (CntW+1)'(timing.recovery)) begin
					wbd = 1'b1;
				end else begin
					s.tick = tick_inc[CntW-1:0];
				end
			end
			PH_RD_SLOT, PH_POLL: begin
				pull = (s.tick < timing.start);
				if (s.tick == timing.rd_smp) begin
					if (s.phase == PH_RD_SLOT) begin
						s.shift = {bus_in, s.shift[7:1]};
					end else begin
						s.shift = {7'd0, bus_in};
					end
				end
				if (tick_inc >= rlen) begin
					if (s.phase == PH_POLL) begin
						if (s.shift[0]) begin
							fin = 1'b1;
						end else begin
							s.tick  = '0;
							s.shift = '0;
						end
					end else if (s.bit_idx == 3'd7) begin
						s.rx = s.shift;
						fin  = 1'b1;
					end else begin
						s.bit_idx = s.bit_idx + 3'd1;
						s.tick    = '0;
					end
				end else begin
					s.tick = tick_inc[CntW-1:0];
				end
			end
			default: ;
		endcase

		// end of a write bit slot (with its recovery)
		if (wbd) begin
			s.shift = {1'b0, s.shift[7:1]};
			if (s.bit_idx == 3'd7) begin
				fin = 1'b1;
			end else begin
				s.bit_idx = s.bit_idx + 3'd1;
				s.phase   = PH_WR_SLOT;
				s.tick    = '0;
			end
		end

		// end of one bus operation: next step of a temperature read, or done
		if (fin) begin
			if (s.tmode && !s.err && s.step < 4'd8) begin
				if (s.step == 4'd7) begin
					s.temp[7:0] = s.rx;
				end
				s.step    = s.step + 4'd1;
				s.tick    = '0;
				s.bit_idx = '0;
				s.shift   = '0;
				case (s.step)
					4'd4:       s.phase = PH_RST_LOW;
					4'd1, 4'd5: begin
						s.phase = PH_WR_SLOT;
						s.shift = OW_SKIP_ROM;
					end
					4'd2: begin
						s.phase = PH_WR_SLOT;
						s.shift = OW_CONVERT;
					end
					4'd3:       s.phase = PH_POLL;
					4'd6: begin
						s.phase = PH_WR_SLOT;
						s.shift = OW_READ_PAD;
					end
					default:    s.phase = PH_RD_SLOT;
				endcase
			end else begin
				if (s.tmode && !s.err) begin
					s.temp[15:8] = s.rx;
				end
				s.phase = PH_IDLE;
				done    = 1'b1;
			end
		end

		res.pull = pull;
		res.busy = (s.phase != PH_IDLE);
		res.done = done;
		res.err  = s.err;
		res.rx   = s.rx;
		res.temp = s.temp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (en) begin
			st_q <= s;
		end
	end

	// a finished sequence never reports busy on the same tick
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !res.busy)
		else $error("done together with busy");

	// the temperature step counter stops at the second scratchpad byte
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.step <= 4'd8)
		else $error("sequence step out of range");

	// a plain tick (or a meaningless code) leaves an idle sequencer idle
	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(en && st_q.phase == PH_IDLE && (command == CMD_TICK || command > CMD_TEMP))
		|=> st_q.phase == PH_IDLE)
		else $error("idle sequencer started without a command");

	// state only moves when a word is processed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(st_q))
		else $error("sequencer state moved without a word");

endmodule

`default_nettype wire

// ----- rtl/one_wire_temperature_master.sv -----
// ----------------------------------------------------------------------------
// one_wire_temperature_master: single-wire bus master with temperature read
// Each input word is one bus tick; each tick gives one result word with the
// pull-low level, busy/done/error status, last read byte and last raw
// temperature.
//
//  channel | signals                               | direction | word
//  --------+---------------------------------------+-----------+----------------
//  in      | in_valid, in_ready                    | to block  | command, tx_byte,
//          |                                       |           | bus_in
//  out     | out_valid, out_ready                  | from block| bus_pull_low,
//          |                                       |           | busy_res, done_res,
//          |                                       |           | error_code, rx_byte,
//          |                                       |           | temperature
//  cfg     | cfg_we, cfg_index, cfg_data           | to block  | timing register
//
//  Rate: one word per clock while out_ready stays high; a word taken into the
//  input register moves on into the result register, and its result word is
//  offered from there.
//  The sequencer state and result register update together when the stored
//  input word moves on; that single step sets the rate.
//  Reset: arst_n clears both stages, the sequencer (idle, no error, zero
//  temperature) and loads the default timing.
//  Stalls: with out_ready low the result holds and one more input word is
//  taken into the input register; in_ready then drops until the result goes.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_temperature_master (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input words
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   command,
	input  wire logic [7:0]                   tx_byte,
	input  wire logic                         bus_in,
	// result words
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              bus_pull_low,
	output logic                              busy_res,
	output logic                              done_res,
	output logic                              error_code,
	output logic [7:0]                        rx_byte,
	output logic signed [15:0]                temperature,
	// timing registers
	input  wire logic                         cfg_we,
	input  wire logic [owtm_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [owtm_pkg::RegW-1:0]    cfg_data
);
	import owtm_pkg::*;

	timing_t timing;
	result_t res;

	// input register
	logic       v_s1;
	logic [2:0] cmd_s1;
	logic [7:0] tx_s1;
	logic       bus_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;

	logic advance;

	// stored tick moves on when the result register is free or being drained
	assign advance  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// payload registers need no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= command;
			tx_s1  <= tx_byte;
			bus_s1 <= bus_in;
		end
	end

	owtm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	// sequencer steps once per tick word as it leaves the input register
	owtm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.command (cmd_s1),
		.tx_byte (tx_s1),
		.bus_in  (bus_s1),
		.timing  (timing),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign bus_pull_low = res_q.pull;
	assign busy_res     = res_q.busy;
	assign done_res     = res_q.done;
	assign error_code   = res_q.err;
	assign rx_byte      = res_q.rx;
	assign temperature  = $signed(res_q.temp);

endmodule

`default_nettype wire

// ----- tb/tb_one_wire_temperature_master.sv -----
// ----------------------------------------------------------------------------
// tb_one_wire_temperature_master: self-checking bench for the bus master
// Tick words go in through a queue-fed driver. A cycle-level model of the
// sequencer predicts each result word, and the monitor checks every field of
// every word. A planning copy of the same model picks the bus_in level for
// each tick, so presence pulses and conversion-done polls show up where the
// sequencer samples them. Timing registers change only while the master is
// idle. The run covers idle ticks at default timing, all-zero timing, odd
// slot shapes and random small timing, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_wire_temperature_master;
	import owtm_pkg::*;

	localparam int HOLD_CYCLES   = 300;  // long receiver stall, fills the pipe
	localparam int RANDOM_WORDS  = 250;  // busy ticks in the random part
	localparam int SETTLE_CYCLES = 4;    // two-stage pipe plus margin

	// how the planner answers a presence sample
	localparam logic [1:0] PRES_RANDOM = 2'd0;
	localparam logic [1:0] PRES_FORCE  = 2'd1;
	localparam logic [1:0] PRES_NONE   = 2'd2;

	// steps of the temperature read sequence
	localparam logic [3:0] STEP_RST1      = 4'd0;
	localparam logic [3:0] STEP_SKIP1     = 4'd1;
	localparam logic [3:0] STEP_CONVERT   = 4'd2;
	localparam logic [3:0] STEP_POLL      = 4'd3;
	localparam logic [3:0] STEP_RST2      = 4'd4;
	localparam logic [3:0] STEP_SKIP2     = 4'd5;
	localparam logic [3:0] STEP_READ_PAD  = 4'd6;
	localparam logic [3:0] STEP_LOW_BYTE  = 4'd7;
	localparam logic [3:0] STEP_HIGH_BYTE = 4'd8;

	typedef enum logic [2:0] {
		LN_IDLE, LN_RST_LOW, LN_RST_WAIT, LN_RST_REC,
		LN_WR_SLOT, LN_WR_REC, LN_RD_SLOT, LN_POLL
	} line_phase_t;

	// sequencer state plus the two per-tick outputs that are not state
	typedef struct packed {
		line_phase_t ph;
		logic [9:0]  tcnt;
		logic [2:0]  bidx;
		logic [7:0]  shreg;
		logic [3:0]  step;
		logic [15:0] temp;
		logic        err;
		logic [2:0]  cmd;
		logic [7:0]  rx;
		logic        pull;
		logic        done;
	} master_state_t;

	typedef logic [5:0][RegW-1:0] timing_regs_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx;
		logic       bus;
	} tick_word_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [2:0]          command     = CMD_TICK;
	logic [7:0]          tx_byte     = 8'h00;
	logic                bus_in      = 1'b1;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic                bus_pull_low;
	logic                busy_res;
	logic                done_res;
	logic                error_code;
	logic [7:0]          rx_byte;
	logic signed [15:0]  temperature;
	logic                cfg_we      = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index   = REG_RST_LOW;
	logic [RegW-1:0]     cfg_data    = '0;

	one_wire_temperature_master DUT (.*);

	// checker copy of the sequencer, advanced on each accepted word
	master_state_t seq_model;
	timing_regs_t  regs_model;
	// planning copy, advanced as words are queued
	master_state_t seq_plan;
	timing_regs_t  regs_plan;

	tick_word_t words_to_send[$];
	result_t    results_due[$];

	int         mismatches   = 0;
	int         busy_words   = 0;
	logic [1:0] presence_mode = PRES_FORCE;
	logic       gaps_on      = 1'b1;
	logic       calm         = 1'b0;   // no idling at all near the end
	logic       hold_req     = 1'b0;
	logic       hold_taken   = 1'b0;
	int         hold_left    = 0;
	int         send_gap     = 0;
	int         rcv_gap      = 0;
	result_t    seen_word;
	result_t    due_word;

	// ------------------------------------------------------------------------
	// Sequencer model
	// ------------------------------------------------------------------------
	function automatic timing_regs_t default_regs();
		timing_regs_t r;
		r[REG_RST_LOW]  = RST_LOW_DEF;
		r[REG_PRES]     = PRES_DEF;
		r[REG_SLOT]     = SLOT_DEF;
		r[REG_RD_SMP]   = RD_SMP_DEF;
		r[REG_RECOVERY] = RECOVERY_DEF;
		r[REG_START]    = START_DEF;
		return r;
	endfunction

	// lengths of reset low, slot and start pulse read zero as one
	function automatic int unsigned reg_len(timing_regs_t r, reg_idx_t k, bit min1);
		int unsigned v;
		v = 32'(r[k]);
		if (min1 && v == 0)
			v = 1;
		return v;
	endfunction

	function automatic master_state_t open_op(master_state_t s, line_phase_t ph,
			logic [7:0] b);
		s.ph    = ph;
		s.tcnt  = '0;
		s.bidx  = '0;
		s.shreg = b;
		return s;
	endfunction

	function automatic master_state_t open_step(master_state_t s);
		case (s.step)
			STEP_RST1, STEP_RST2:   s = open_op(s, LN_RST_LOW, 8'h00);
			STEP_SKIP1, STEP_SKIP2: s = open_op(s, LN_WR_SLOT, OW_SKIP_ROM);
			STEP_CONVERT:           s = open_op(s, LN_WR_SLOT, OW_CONVERT);
			STEP_POLL:              s = open_op(s, LN_POLL, 8'h00);
			STEP_READ_PAD:          s = open_op(s, LN_WR_SLOT, OW_READ_PAD);
			default:                s = open_op(s, LN_RD_SLOT, 8'h00);
		endcase
		return s;
	endfunction

	// end of one bus operation: next step of a temperature read, or done
	function automatic master_state_t close_op(master_state_t s);
		if (s.cmd == CMD_TEMP && !s.err) begin
			if (s.step == STEP_LOW_BYTE)
				s.temp = {8'h00, s.rx};
			else if (s.step == STEP_HIGH_BYTE)
				s.temp = {s.rx, s.temp[7:0]};
			if (s.step < STEP_HIGH_BYTE) begin
				s.step = s.step + 4'd1;
				return open_step(s);
			end
		end
		s.ph   = LN_IDLE;
		s.done = 1'b1;
		return s;
	endfunction

	function automatic master_state_t reset_wait_tick(master_state_t s, timing_regs_t r);
		if (s.tcnt + 1 >= reg_len(r, REG_RST_LOW, 1'b1))
			return close_op(s);
		s.tcnt = s.tcnt + 10'd1;
		return s;
	endfunction

	function automatic master_state_t bit_sent(master_state_t s);
		s.shreg = s.shreg >> 1;
		if (s.bidx >= 3'd7)
			return close_op(s);
		s.bidx = s.bidx + 3'd1;
		s.ph   = LN_WR_SLOT;
		s.tcnt = '0;
		return s;
	endfunction

	function automatic master_state_t next_master_state(master_state_t s, timing_regs_t r,
			logic [2:0] c, logic [7:0] t, logic b);
		int unsigned slot, start, smp, low, rlen;
		slot   = reg_len(r, REG_SLOT, 1'b1);
		start  = reg_len(r, REG_START, 1'b1);
		smp    = reg_len(r, REG_RD_SMP, 1'b0);
		s.done = 1'b0;
		s.pull = 1'b0;
		// an idle master takes a command; 5..7 count as plain ticks
		if (s.ph == LN_IDLE && c >= CMD_RESET && c <= CMD_TEMP) begin
			s.err  = 1'b0;
			s.cmd  = c;
			s.step = STEP_RST1;
			case (c)
				CMD_RESET: s = open_op(s, LN_RST_LOW, 8'h00);
				CMD_WRITE: s = open_op(s, LN_WR_SLOT, t);
				CMD_READ:  s = open_op(s, LN_RD_SLOT, 8'h00);
				default: begin
					s.temp = '0;
					s = open_step(s);
				end
			endcase
		end
		case (s.ph)
			LN_RST_LOW: begin
				s.pull = 1'b1;
				if (s.tcnt + 1 >= reg_len(r, REG_RST_LOW, 1'b1)) begin
					s.ph   = LN_RST_WAIT;
					s.tcnt = '0;
				end else
					s.tcnt = s.tcnt + 10'd1;
			end
			LN_RST_WAIT: begin
				// presence sample: a released line means nobody answered
				if (s.tcnt >= reg_len(r, REG_PRES, 1'b0)) begin
					s.err  = b;
					s.ph   = LN_RST_REC;
					s.tcnt = '0;
					s = reset_wait_tick(s, r);
				end else
					s.tcnt = s.tcnt + 10'd1;
			end
			LN_RST_REC: s = reset_wait_tick(s, r);
			LN_WR_SLOT: begin
				low    = s.shreg[0] ? start : slot;
				s.pull = (s.tcnt < low);
				if (s.tcnt + 1 >= slot) begin
					if (reg_len(r, REG_RECOVERY, 1'b0) == 0)
						s = bit_sent(s);
					else begin
						s.ph   = LN_WR_REC;
						s.tcnt = '0;
					end
				end else
					s.tcnt = s.tcnt + 10'd1;
			end
			LN_WR_REC: begin
				if (s.tcnt + 1 >= reg_len(r, REG_RECOVERY, 1'b0))
					s = bit_sent(s);
				else
					s.tcnt = s.tcnt + 10'd1;
			end
			LN_RD_SLOT, LN_POLL: begin
				s.pull = (s.tcnt < start);
				if (s.tcnt == smp)
					s.shreg = (s.ph == LN_RD_SLOT) ? {b, s.shreg[7:1]} : {7'd0, b};
				// the slot stretches to cover a late sample
				rlen = (slot > smp) ? slot : smp + 1;
				if (s.tcnt + 1 >= rlen) begin
					if (s.ph == LN_POLL) begin
						if (s.shreg[0])
							s = close_op(s);
						else begin
							s.tcnt  = '0;
							s.shreg = '0;
						end
					end else if (s.bidx >= 3'd7) begin
						s.rx = s.shreg;
						s = close_op(s);
					end else begin
						s.bidx = s.bidx + 3'd1;
						s.tcnt = '0;
					end
				end else
					s.tcnt = s.tcnt + 10'd1;
			end
			default: ;
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: feeds words from the queue; predicts on every accepted word
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command  <= CMD_TICK;
			tx_byte  <= 8'h00;
			bus_in   <= 1'b1;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				seq_model = next_master_state(seq_model, regs_model, command, tx_byte, bus_in);
				results_due.push_back({seq_model.pull, seq_model.ph != LN_IDLE,
					seq_model.done, seq_model.err, seq_model.rx, seq_model.temp});
			end
			// payload only moves once the current word is gone
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (words_to_send.size() != 0) begin
					tick_word_t w;
					w = words_to_send.pop_front();
					in_valid <= 1'b1;
					command  <= w.cmd;
					tx_byte  <= w.tx;
					bus_in   <= w.bus;
					// idle burst after this word
					if (gaps_on && !calm && $urandom_range(0, 15) == 0)
						send_gap <= $urandom_range(1, 17);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: ready pattern and result check against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_taken <= 1'b0;
			hold_left  <= 0;
			rcv_gap    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_word = {bus_pull_low, busy_res, done_res, error_code, rx_byte,
					temperature};
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with nothing predicted", $realtime);
				end else begin
					due_word = results_due.pop_front();
					if (seen_word !== due_word) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp/got pull %b/%b busy %b/%b done %b/%b",
								$realtime, due_word.pull, seen_word.pull, due_word.busy,
								seen_word.busy, due_word.done, seen_word.done);
							$display("    err %b/%b rx %h/%h temp %h/%h",
								due_word.err, seen_word.err, due_word.rx, seen_word.rx,
								due_word.temp, seen_word.temp);
						end
					end
				end
			end
			// one long hold on request, otherwise short random bursts
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_taken) begin
				out_ready  <= 1'b0;
				hold_taken <= 1'b1;
				hold_left  <= HOLD_CYCLES;
			end else if (rcv_gap != 0) begin
				out_ready <= 1'b0;
				rcv_gap   <= rcv_gap - 1;
			end else if (gaps_on && !calm && $urandom_range(0, 15) == 0) begin
				out_ready <= 1'b0;
				rcv_gap   <= $urandom_range(0, 16);
			end else
				out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	// queue one tick word; bus_in is steered only where the master samples it
	task automatic offer(input logic [2:0] c, input logic [7:0] t);
		master_state_t lo, hi;
		tick_word_t    w;
		logic          b;
		lo = next_master_state(seq_plan, regs_plan, c, t, 1'b0);
		hi = next_master_state(seq_plan, regs_plan, c, t, 1'b1);
		if (lo == hi)
			b = 1'($urandom_range(0, 1));
		else if (lo.err != hi.err) begin
			// presence sample: low line means a device answered
			case (presence_mode)
				PRES_FORCE: b = 1'b0;
				PRES_NONE:  b = 1'b1;
				default:    b = ($urandom_range(0, 7) == 0);
			endcase
		end else if (lo.ph == LN_POLL)
			b = ($urandom_range(0, 2) == 0);   // conversion finishes now and then
		else
			b = 1'($urandom_range(0, 1));
		if (seq_plan.ph != LN_IDLE || (b ? hi.ph : lo.ph) != LN_IDLE)
			busy_words++;
		seq_plan = b ? hi : lo;
		w.cmd = c;
		w.tx  = t;
		w.bus = b;
		words_to_send.push_back(w);
	endtask

	// command word, then ticks until the sequence ends; some stray commands
	// land while busy and must be ignored
	task automatic run_command(input logic [2:0] c, input logic [7:0] t);
		offer(c, t);
		while (seq_plan.ph != LN_IDLE) begin
			if ($urandom_range(0, 15) == 0)
				offer(3'($urandom_range(0, 7)), 8'($urandom));
			else
				offer(CMD_TICK, 8'($urandom));
		end
	endtask

	// sender pauses until every predicted word has come back
	task automatic settle();
		@(negedge clk);
		while (words_to_send.size() != 0 || results_due.size() != 0 || in_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input reg_idx_t i, input logic [RegW-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= i;
		cfg_data  <= v;
		regs_model[i] = v;
		regs_plan[i]  = v;
	endtask

	// only called with the master idle and nothing in flight
	task automatic set_timing(input logic [RegW-1:0] rl, pr, sl, rs, rc, st);
		put_reg(REG_RST_LOW, rl);
		put_reg(REG_PRES, pr);
		put_reg(REG_SLOT, sl);
		put_reg(REG_RD_SMP, rs);
		put_reg(REG_RECOVERY, rc);
		put_reg(REG_START, st);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly tiny lengths so sequences stay short, now and then longer
	function automatic logic [RegW-1:0] pick_len();
		if ($urandom_range(0, 15) == 0)
			return RegW'($urandom_range(0, 12));
		return RegW'($urandom_range(0, 5));
	endfunction

	initial begin
		seq_model  = '0;
		seq_plan   = '0;
		regs_model = default_regs();
		regs_plan  = default_regs();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default timing: idle ticks, spare command codes act as ticks
		offer(CMD_TICK, 8'h00);
		for (int c = CMD_TEMP + 1; c < 8; c++)
			offer(3'(c), 8'hff);

		// zero lengths: clamped to one, recovery skipped, sample on tick 0
		settle();
		set_timing('0, '0, '0, '0, '0, '0);
		run_command(CMD_RESET, 8'h00);
		presence_mode = PRES_NONE;
		run_command(CMD_RESET, 8'hff);
		run_command(CMD_TEMP, 8'h00);       // stops right after the first reset
		presence_mode = PRES_FORCE;
		run_command(CMD_WRITE, 8'h00);
		run_command(CMD_WRITE, 8'hff);
		run_command(CMD_TEMP, 8'h00);
		run_command(CMD_WRITE, 8'ha5);
		run_command(CMD_READ, 8'h00);

		// start pulse longer than the slot: low for the whole slot
		settle();
		set_timing(10'd4, 10'd0, 10'd3, 10'd1, 10'd0, 10'd7);
		run_command(CMD_WRITE, 8'h96);
		run_command(CMD_READ, 8'h00);

		// read sample inside the start pulse
		settle();
		set_timing(10'd2, 10'd1, 10'd5, 10'd2, 10'd1, 10'd4);
		run_command(CMD_READ, 8'h00);

		// read sample past the end of the slot stretches the slot
		settle();
		set_timing(10'd3, 10'd2, 10'd2, 10'd6, 10'd0, 10'd1);
		run_command(CMD_READ, 8'h00);

		// random part: small random timing per setting, random commands
		presence_mode = PRES_RANDOM;
		busy_words    = 0;
		while (busy_words < RANDOM_WORDS) begin
			settle();
			gaps_on = ($urandom_range(0, 3) != 0);
			set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
				pick_len());
			hold_req = 1'b1;   // taken once, in the first random setting
			repeat ($urandom_range(2, 5)) begin
				// idle noise: plain ticks and spare codes only
				repeat ($urandom_range(0, 3))
					offer(($urandom_range(0, 1) != 0) ? CMD_TICK :
						3'($urandom_range(CMD_TEMP + 1, 7)), 8'($urandom));
				run_command(3'($urandom_range(CMD_RESET, CMD_TEMP)), 8'($urandom));
			end
		end

		// last stretch at full rate on both sides
		settle();
		calm = 1'b1;
		set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
		run_command(CMD_RESET, 8'($urandom));
		run_command(CMD_WRITE, 8'($urandom));
		run_command(CMD_READ, 8'($urandom));
		settle();

		if (mismatches == 0 && results_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#30000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/owtm_pkg.sv
rtl/owtm_cfg.sv
rtl/owtm_core.sv
rtl/one_wire_temperature_master.sv
tb/tb_one_wire_temperature_master.sv
